[design/kli_pkg.sv]
// shared constants, codes and types for the keyframe linear interpolator
package kli_pkg;

  // table sizes
  localparam int MaxKeys     = 16;
  localparam int MaxChannels = 8;

  // field and index widths
  localparam int KeyW     = $clog2(MaxKeys);
  localparam int ChanW    = $clog2(MaxChannels);
  localparam int ValAddrW = KeyW + ChanW;
  localparam int NumKeysW = 5;
  localparam int NumChW   = 4;
  localparam int TimeW    = 16;
  localparam int ValW     = 32;
  localparam int ReqW     = 2;
  localparam int CfgAddrW = 2;
  localparam int CfgDataW = 5;

  // divider: value-times-time dividend over a time divisor
  localparam int DivNumW = ValW + TimeW;
  localparam int DivQuoW = ValW;
  localparam int DivCntW = $clog2(DivQuoW);

  // request codes
  typedef enum logic [ReqW-1:0] {
    ReqWrTime  = 2'd0,
    ReqWrValue = 2'd1,
    ReqEval    = 2'd2
  } req_e;

  // configuration register indexes
  typedef enum logic [CfgAddrW-1:0] {
    CfgNumKeys     = 2'd0,
    CfgNumChannels = 2'd1,
    CfgLooped      = 2'd2
  } cfg_e;

  // sequencer states
  typedef enum logic [3:0] {
    StIdle,
    StModRd,
    StModDiv,
    StSrchRd,
    StSrchCmp,
    StValRd0,
    StValRd1,
    StValSub,
    StValMul,
    StValDiv
  } kli_state_e;

endpackage

[design/kli_ram.sv]
// generic single-port synchronous ram with registered read
module kli_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/kli_div.sv]
// radix-2 restoring divider, one quotient bit per cycle
module kli_div
  import kli_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DivNumW-1:0] num_i,
  input  logic [TimeW-1:0]   den_i,
  output logic               done_o,
  output logic [DivQuoW-1:0] quo_o,
  output logic [TimeW-1:0]   rem_o
);

  logic               active_q, active_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [TimeW-1:0]   rem_q, rem_d;
  logic [TimeW-1:0]   den_q, den_d;
  logic [DivQuoW-1:0] sh_q, sh_d;
  logic [TimeW:0]     trial;
  logic [TimeW:0]     diff;
  logic               ge;

  // one trial subtraction
  assign trial = {rem_q, sh_q[DivQuoW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});

  // step control; the upper dividend part is below the divisor by construction
  always_comb begin
    active_d = active_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    rem_d    = rem_q;
    den_d    = den_q;
    sh_d     = sh_q;
    if (start_i) begin
      active_d = 1'b1;
      cnt_d    = '0;
      rem_d    = num_i[DivNumW-1:DivQuoW];
      sh_d     = num_i[DivQuoW-1:0];
      den_d    = den_i;
    end else if (active_q) begin
      rem_d = ge ? diff[TimeW-1:0] : trial[TimeW-1:0];
      sh_d  = {sh_q[DivQuoW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DivCntW'(DivQuoW - 1)) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      done_q   <= done_d;
      cnt_q    <= cnt_d;
    end
  end

  // operand and partial result registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    sh_q  <= sh_d;
  end

  assign done_o = done_q;
  assign quo_o  = sh_q;
  assign rem_o  = rem_q;

endmodule

[design/keyframe_linear_interpolator.sv]
// top level: key tables in ram, serial key search, per-channel interpolation
//
// Usage: a word on the input side is taken at a clock edge with start high and
// busy low. Key time and key value writes go straight into the tables and
// keep busy low, so they can follow each other every cycle. An evaluate word
// raises busy until its last result is out.
// Each result word is on out_*_o for one cycle with out_strobe_o high;
// last_result_o marks the final channel. The receiver cannot stall the block.
// Steps of an evaluate, from the accepting edge: the optional wrap is one time
// ram read, then the shared divider; the key search takes a read state and a
// compare state per key visited (the time ram has one port and a registered
// read); then each channel passes the value read states when a key value is
// held, or the value reads, a subtract, a multiply and the divider when
// interpolating. Each result word leaves through one output register.
// Config registers (num_keys, num_channels, looped) are written through
// cfg_we_i/cfg_addr_i/cfg_wdata_i; the user must write them only while busy
// is low, as the block itself does not enforce this.
// Reset sets num_keys 1, num_channels 1, looped 0 and idles the sequencer;
// the key tables hold no defined contents until written.
module keyframe_linear_interpolator
  import kli_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [ReqW-1:0]         req_type_i,
  input  logic [KeyW-1:0]         key_index_i,
  input  logic [ChanW-1:0]        channel_sel_i,
  input  logic [TimeW-1:0]        key_time_i,
  input  logic signed [ValW-1:0]  key_value_i,
  input  logic [TimeW-1:0]        eval_time_i,
  input  logic                    cfg_we_i,
  input  logic [CfgAddrW-1:0]     cfg_addr_i,
  input  logic [CfgDataW-1:0]     cfg_wdata_i,
  output logic                    out_strobe_o,
  output logic [ChanW-1:0]        out_channel_o,
  output logic signed [ValW-1:0]  out_value_o,
  output logic                    last_result_o
);

  kli_state_e state_q, state_d;

  logic [NumKeysW-1:0] num_keys_q;
  logic [NumChW-1:0]   num_ch_q;
  logic                looped_q;

  logic [TimeW-1:0] t_q, t_d;
  logic [KeyW-1:0]  k_q, k_d;
  logic [TimeW-1:0] tprev_q, tprev_d;
  logic             hold_q, hold_d;
  logic [KeyW-1:0]  hk_q, hk_d;
  logic [TimeW-1:0] d_q, d_d;
  logic [TimeW-1:0] dt_q, dt_d;
  logic [ChanW-1:0] chan_q, chan_d;
  logic [ValW-1:0]  v0_q, v0_d;
  logic             neg_q, neg_d;
  logic [ValW-1:0]  mag_q, mag_d;

  logic             out_strobe_q, out_strobe_d;
  logic [ChanW-1:0] out_channel_q, out_channel_d;
  logic [ValW-1:0]  out_value_q, out_value_d;
  logic             out_last_q, out_last_d;

  logic                accept;
  logic                eval_req;
  logic [NumKeysW-1:0] nk_eff;
  logic [NumChW-1:0]   nc_eff;
  logic [KeyW-1:0]     last_key;
  logic [ChanW-1:0]    last_chan;
  logic                is_last_chan;

  logic                time_we;
  logic [KeyW-1:0]     time_addr;
  logic [TimeW-1:0]    time_rdata;
  logic                val_we;
  logic [ValAddrW-1:0] val_addr;
  logic [ValW-1:0]     val_rdata;

  logic               div_start;
  logic [DivNumW-1:0] div_num;
  logic [TimeW-1:0]   div_den;
  logic               div_done;
  logic [DivQuoW-1:0] div_quo;
  logic [TimeW-1:0]   div_rem;

  logic signed [ValW:0]   diff;
  logic [ValW:0]          q_adj;
  logic signed [ValW+1:0] q_signed;
  logic signed [ValW+1:0] interp;

  // handshake and effective counts
  assign busy     = (state_q != StIdle);
  assign accept   = start && !busy;
  assign eval_req = (req_type_i == ReqEval);

  assign nk_eff = (num_keys_q == '0) ? NumKeysW'(1) :
                  (num_keys_q > NumKeysW'(MaxKeys)) ? NumKeysW'(MaxKeys) : num_keys_q;
  assign nc_eff = (num_ch_q == '0) ? NumChW'(1) :
                  (num_ch_q > NumChW'(MaxChannels)) ? NumChW'(MaxChannels) : num_ch_q;
  assign last_key     = KeyW'(nk_eff - NumKeysW'(1));
  assign last_chan    = ChanW'(nc_eff - NumChW'(1));
  assign is_last_chan = (chan_q == last_chan);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_keys_q <= NumKeysW'(1);
      num_ch_q   <= NumChW'(1);
      looped_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_e'(cfg_addr_i))
        CfgNumKeys:     num_keys_q <= cfg_wdata_i[NumKeysW-1:0];
        CfgNumChannels: num_ch_q   <= cfg_wdata_i[NumChW-1:0];
        CfgLooped:      looped_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // key time table
  assign time_we   = accept && (req_type_i == ReqWrTime);
  assign time_addr = (state_q == StIdle) ? (time_we ? key_index_i : last_key) :
                     (state_q == StSrchRd) ? k_q : last_key;

  kli_ram #(
    .Width (TimeW),
    .Depth (MaxKeys)
  ) u_time_ram (
    .clk_i   (clk_i),
    .we_i    (time_we),
    .addr_i  (time_addr),
    .wdata_i (key_time_i),
    .rdata_o (time_rdata)
  );

  // key value table, entry key*MaxChannels+channel
  assign val_we = accept && (req_type_i == ReqWrValue);
  always_comb begin
    case (state_q)
      StIdle:   val_addr = {key_index_i, channel_sel_i};
      StValRd0: val_addr = {hold_q ? hk_q : (hk_q - KeyW'(1)), chan_q};
      default:  val_addr = {hk_q, chan_q};
    endcase
  end

  kli_ram #(
    .Width (ValW),
    .Depth (MaxKeys * MaxChannels)
  ) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .addr_i  (val_addr),
    .wdata_i (key_value_i),
    .rdata_o (val_rdata)
  );

  // shared divider: time wrap and interpolation fraction
  kli_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  // floored result: negative slopes round the magnitude quotient up
  assign diff     = $signed({val_rdata[ValW-1], val_rdata}) - $signed({v0_q[ValW-1], v0_q});
  assign q_adj    = {1'b0, div_quo} + (ValW+1)'(neg_q && (div_rem != '0));
  assign q_signed = neg_q ? -$signed({1'b0, q_adj}) : $signed({1'b0, q_adj});
  assign interp   = $signed({{2{v0_q[ValW-1]}}, v0_q}) + q_signed;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (accept && eval_req) begin
          if (nk_eff == NumKeysW'(1)) state_d = StValRd0;
          else if (looped_q)          state_d = StModRd;
          else                        state_d = StSrchRd;
        end
      end
      StModRd:   state_d = (time_rdata != '0) ? StModDiv : StSrchRd;
      StModDiv:  if (div_done) state_d = StSrchRd;
      StSrchRd:  state_d = StSrchCmp;
      StSrchCmp: begin
        if (k_q == '0)                state_d = StSrchRd;
        else if (t_q < time_rdata)    state_d = StValRd0;
        else if (k_q == last_key)     state_d = StValRd0;
        else                          state_d = StSrchRd;
      end
      StValRd0:  state_d = StValRd1;
      StValRd1: begin
        if (!hold_q)           state_d = StValSub;
        else if (is_last_chan) state_d = StIdle;
        else                   state_d = StValRd0;
      end
      StValSub:  state_d = StValMul;
      StValMul:  state_d = StValDiv;
      StValDiv: begin
        if (div_done) state_d = is_last_chan ? StIdle : StValRd0;
      end
      default:   state_d = StIdle;
    endcase
  end

  // datapath and result word
  always_comb begin
    t_d           = t_q;
    k_d           = k_q;
    tprev_d       = tprev_q;
    hold_d        = hold_q;
    hk_d          = hk_q;
    d_d           = d_q;
    dt_d          = dt_q;
    chan_d        = chan_q;
    v0_d          = v0_q;
    neg_d         = neg_q;
    mag_d         = mag_q;
    out_strobe_d  = 1'b0;
    out_channel_d = out_channel_q;
    out_value_d   = out_value_q;
    out_last_d    = out_last_q;
    div_start     = 1'b0;
    div_num       = {{(DivNumW-TimeW){1'b0}}, t_q};
    div_den       = time_rdata;
    case (state_q)
      StIdle: begin
        if (accept && eval_req) begin
          t_d    = eval_time_i;
          k_d    = '0;
          chan_d = '0;
          hold_d = (nk_eff == NumKeysW'(1));
          hk_d   = '0;
        end
      end
      StModRd: begin
        div_start = (time_rdata != '0);
      end
      StModDiv: begin
        if (div_done) t_d = div_rem;
      end
      StSrchCmp: begin
        if (k_q == '0) begin
          tprev_d = time_rdata;
          k_d     = KeyW'(1);
        end else if (t_q < time_rdata) begin
          if (t_q < tprev_q) begin
            hold_d = 1'b1;
            hk_d   = k_q - KeyW'(1);
          end else begin
            hold_d = 1'b0;
            hk_d   = k_q;
            d_d    = time_rdata - tprev_q;
            dt_d   = t_q - tprev_q;
          end
        end else begin
          tprev_d = time_rdata;
          if (k_q == last_key) begin
            hold_d = 1'b1;
            hk_d   = k_q;
          end else begin
            k_d = k_q + KeyW'(1);
          end
        end
      end
      StValRd1: begin
        v0_d = val_rdata;
        if (hold_q) begin
          out_strobe_d  = 1'b1;
          out_channel_d = chan_q;
          out_value_d   = val_rdata;
          out_last_d    = is_last_chan;
          if (!is_last_chan) chan_d = chan_q + ChanW'(1);
        end
      end
      StValSub: begin
        neg_d = diff[ValW];
        mag_d = diff[ValW] ? ValW'(-diff) : diff[ValW-1:0];
      end
      StValMul: begin
        div_start = 1'b1;
        div_num   = {{(DivNumW-ValW){1'b0}}, mag_q} * {{(DivNumW-TimeW){1'b0}}, dt_q};
        div_den   = d_q;
      end
      StValDiv: begin
        if (div_done) begin
          out_strobe_d  = 1'b1;
          out_channel_d = chan_q;
          out_value_d   = interp[ValW-1:0];
          out_last_d    = is_last_chan;
          if (!is_last_chan) chan_d = chan_q + ChanW'(1);
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      out_strobe_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      out_strobe_q <= out_strobe_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    t_q           <= t_d;
    k_q           <= k_d;
    tprev_q       <= tprev_d;
    hold_q        <= hold_d;
    hk_q          <= hk_d;
    d_q           <= d_d;
    dt_q          <= dt_d;
    chan_q        <= chan_d;
    v0_q          <= v0_d;
    neg_q         <= neg_d;
    mag_q         <= mag_d;
    out_channel_q <= out_channel_d;
    out_value_q   <= out_value_d;
    out_last_q    <= out_last_d;
  end

  assign out_strobe_o  = out_strobe_q;
  assign out_channel_o = out_channel_q;
  assign out_value_o   = out_value_q;
  assign last_result_o = out_last_q;

`ifndef SYNTHESIS
  // a result word only follows a cycle of evaluation work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o |-> $past(busy))
    else $error("result word without evaluation in progress");

  // more channels pending keeps the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_strobe_o && !out_last_q) |-> busy)
    else $error("evaluation ended before its last channel");

  // an accepted evaluate occupies the sequencer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_type_i == ReqEval) |=> busy)
    else $error("evaluate word accepted without going busy");

  // divider finishes only while a state waits on it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == StModDiv || state_q == StValDiv))
    else $error("divider result with no consumer");
`endif

endmodule
